FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is held
`define SHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define SHA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: sv/sha256_pkg.sv
// types, constants and round functions of the sha-256 engine
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } sha256_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha256_out_t;

    typedef logic [7:0][31:0] sha256_words_t;

    // control from the sequencer to the block buffer / schedule window
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       step;
    } sha256_mctl_t;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic       init;
        logic       load;
        logic       step;
        logic       fold;
        logic [5:0] rnd;
    } sha256_rctl_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam sha256_words_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        logic [63:0] t;
        t = {x, x} >> n;
        return t[31:0];
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

FILE: sv/sha256_msg.sv
// block buffer that doubles as the rolling 16-word message schedule
module sha256_msg (
    input  logic                     clk,
    input  sha256_pkg::sha256_mctl_t ctl,
    output logic [31:0]              w
);
    import sha256_pkg::*;

    // word i of the window sits at bits [511-32*i -: 32], word 0 on top
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  w_new;

    assign w = win_reg[511:480];

    // w[t+16] from w[t+14], w[t+9], w[t+1] and w[t]
    assign w_new = sig1(win_reg[63:32]) + win_reg[223:192]
                 + sig0(win_reg[479:448]) + win_reg[511:480];

    always_comb
    begin
        win_next = win_reg;
        if (ctl.push)
        begin
            win_next = {win_reg[503:0], ctl.push_byte};
        end
        else if (ctl.step)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

FILE: sv/sha256_round.sv
// shared round unit: working words, one round per cycle while step is set, and chaining value
module sha256_round (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sha256_pkg::sha256_rctl_t  ctl,
    input  logic [31:0]               w,
    output sha256_pkg::sha256_words_t chain
);
    import sha256_pkg::*;

    sha256_words_t wk_reg;
    sha256_words_t wk_next;
    sha256_words_t chain_reg;
    sha256_words_t chain_next;
    logic [31:0]   t1;
    logic [31:0]   t2;

    assign chain = chain_reg;

    assign t1 = wk_reg[7] + bsig1(wk_reg[4])
              + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]))
              + K_TABLE[ctl.rnd] + w;
    assign t2 = bsig0(wk_reg[0])
              + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));

    always_comb
    begin
        wk_next    = wk_reg;
        chain_next = chain_reg;
        if (ctl.load)
        begin
            wk_next = chain_reg;
        end
        else if (ctl.step)
        begin
            wk_next = {wk_reg[6], wk_reg[5], wk_reg[4], wk_reg[3] + t1,
                       wk_reg[2], wk_reg[1], wk_reg[0], t1 + t2};
        end
        if (ctl.init)
        begin
            chain_next = INIT_HASH;
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i[2:0]] = chain_reg[i[2:0]] + wk_reg[i[2:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wk_reg <= wk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_HASH;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

endmodule

FILE: sv/sha256_hash_engine_unit.sv
// sha-256 engine top level: byte intake, padding sequencer and digest output
// a byte request is taken while idle; one that fills a block starts a compression
// (64 rounds on the shared round unit, then a fold into the chaining value)
// a last request adds one padding byte per cycle up to the block end, one or two
// compressions, then eight digest words, one per cycle while not stalled
// requests stall during all of these; reset restores the initial hash and clears the count
module sha256_hash_engine_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    msg_valid,
    output logic                    msg_stall,
    input  sha256_pkg::sha256_in_t  msg_item,
    output logic                    digest_valid,
    input  logic                    digest_stall,
    output sha256_pkg::sha256_out_t digest_item
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_PAD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [5:0] LEN_SLOT   = 6'd56;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    ret_reg, ret_next;
    logic [5:0]    rnd_reg, rnd_next;
    logic [5:0]    fill_reg, fill_next;
    logic [60:0]   cnt_reg, cnt_next;
    logic          mark_reg, mark_next;
    logic          final_reg, final_next;
    logic [2:0]    idx_reg, idx_next;
    logic [63:0]   len_bits;
    logic [7:0]    pad_byte;
    sha256_mctl_t  mctl;
    sha256_rctl_t  rctl;
    logic [31:0]   w;
    sha256_words_t chain;

    sha256_msg u_msg (
        .clk (clk),
        .ctl (mctl),
        .w   (w)
    );

    sha256_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rctl),
        .w     (w),
        .chain (chain)
    );

    assign len_bits = {cnt_reg, 3'b000};

    // 0x80 first, then zeros, then the bit length in the last eight slots of the final block
    always_comb
    begin
        if (!mark_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (final_reg && (fill_reg[5:3] == 3'b111))
        begin
            pad_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        rnd_next       = rnd_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        mark_next      = mark_reg;
        final_next     = final_reg;
        idx_next       = idx_reg;
        mctl           = '0;
        rctl           = '0;
        rctl.rnd       = rnd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg_item.last)
                    begin
                        mark_next  = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_PAD;
                    end
                    if (msg_item.has_byte)
                    begin
                        mctl.push      = 1'b1;
                        mctl.push_byte = msg_item.data_byte;
                        fill_next      = fill_reg + 6'd1;
                        cnt_next       = cnt_reg + 61'd1;
                        if (fill_reg == LAST_SLOT)
                        begin
                            rctl.load  = 1'b1;
                            rnd_next   = '0;
                            state_next = ST_CMP;
                            ret_next   = msg_item.last ? ST_PAD : ST_IDLE;
                        end
                    end
                end
            end
            ST_CMP:
            begin
                rctl.step = 1'b1;
                mctl.step = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                rctl.fold  = 1'b1;
                state_next = ret_reg;
            end
            ST_PAD:
            begin
                mctl.push      = 1'b1;
                mctl.push_byte = pad_byte;
                fill_next      = fill_reg + 6'd1;
                mark_next      = 1'b1;
                if (!mark_reg)
                begin
                    // length fits behind the mark only below slot 56
                    final_next = (fill_reg < LEN_SLOT);
                end
                if (fill_reg == LAST_SLOT)
                begin
                    rctl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_CMP;
                    ret_next   = final_reg ? ST_OUT : ST_PAD;
                    final_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!digest_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_INDEX)
                    begin
                        rctl.init  = 1'b1;
                        cnt_next   = '0;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            rnd_reg   <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            mark_reg  <= 1'b0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            mark_reg  <= mark_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);

    assign digest_item.digest_word = chain[idx_reg];
    assign digest_item.word_index  = idx_reg;
    assign digest_item.last_word   = (idx_reg == LAST_INDEX);

endmodule

FILE: sv/sha256_check.sv
// port-level checker for the sha-256 engine, bound to the top level
`include "assert_macros.svh"

module sha256_check (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    msg_stall,
    input logic                    digest_valid,
    input logic                    digest_stall,
    input sha256_pkg::sha256_out_t digest_item
);

    // no request is taken while the digest is going out
    `SHA_ASSERT(a_no_intake_on_out, digest_valid |-> msg_stall, "request taken during digest")

    // digest words come out in order
    `SHA_ASSERT(a_index_step, (digest_valid && !digest_stall && !digest_item.last_word) |=> (digest_valid && ((digest_item.word_index - $past(digest_item.word_index)) == 3'd1)), "digest word skipped")

    // last flag only on the eighth word
    `SHA_ASSERT(a_last_flag, digest_valid |-> (digest_item.last_word == (digest_item.word_index == 3'd7)), "last flag misplaced")

    // the digest ends after its last word is taken
    `SHA_ASSERT(a_end_after_last, (digest_valid && !digest_stall && digest_item.last_word) |=> !digest_valid, "extra digest word")

    // nothing is offered while reset is held
    `SHA_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !digest_valid, "digest during reset")

endmodule

bind sha256_hash_engine_unit sha256_check u_check (.*);

FILE: tb/sv/testbench.sv
// testbench for the sha-256 hash engine: known digests, random messages, stalls on both sides
`timescale 1ns / 1ps

module testbench;
    import sha256_pkg::*;

    localparam int ITEM_COUNT = 350;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int TIMEOUT_NS = 1_000_000;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    typedef struct packed {
        logic [7:0]   data_byte;
        logic         has_byte;
        logic         last;
        logic         known;
        logic [255:0] digest;
    } script_row_t;

    logic        clk;
    logic        rst_n = 1'b1;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    sha256_in_t  msg_item = '0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    sha256_out_t digest_item;

    // hash model state
    logic [31:0] hash_words [8];
    logic [7:0]  block_bytes [64];
    logic [60:0] byte_count;

    sha256_out_t digest_words_q [$];
    script_row_t directed_script [13];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          idle_phase = 0;
    bit          pressure_done = 1'b0;

    sha256_hash_engine_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg_item     (msg_item),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_item  (digest_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 8; i++)
            hash_words[i] = START_HASH[i];
        byte_count = '0;
    endfunction

    function automatic void compress_block_bytes();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int j;
        for (j = 0; j < 16; j++)
            w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2],
                    block_bytes[4*j+3]};
        for (j = 16; j < 64; j++)
        begin
            s0 = ror32(w[j-15], 7) ^ ror32(w[j-15], 18) ^ (w[j-15] >> 3);
            s1 = ror32(w[j-2], 17) ^ ror32(w[j-2], 19) ^ (w[j-2] >> 10);
            w[j] = w[j-16] + s0 + w[j-7] + s1;
        end
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
        for (j = 0; j < 64; j++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[j] + w[j];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
        hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    // returns 1 with the finished digest when the request ends a message
    function automatic bit absorb_request(input sha256_in_t req, output logic [255:0] digest);
        int pos;
        int i;
        logic [63:0] bit_len;
        digest = '0;
        if (req.has_byte)
        begin
            block_bytes[byte_count[5:0]] = req.data_byte;
            byte_count = byte_count + 61'd1;
            if (byte_count[5:0] == 6'd0)
                compress_block_bytes();
        end
        if (!req.last)
            return 1'b0;
        pos = int'(byte_count[5:0]);
        block_bytes[pos] = PAD_BYTE;
        for (i = pos + 1; i < 64; i++)
            block_bytes[i] = 8'h00;
        // no room for the length: it goes into an extra block
        if (pos >= 56)
        begin
            compress_block_bytes();
            for (i = 0; i < 56; i++)
                block_bytes[i] = 8'h00;
        end
        bit_len = {byte_count, 3'b000};
        for (i = 0; i < 8; i++)
            block_bytes[63 - i] = bit_len[8*i +: 8];
        compress_block_bytes();
        for (i = 0; i < 8; i++)
            digest[255 - 32*i -: 32] = hash_words[i];
        restart_hash();
        return 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what, input sha256_out_t want,
                                          input sha256_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected word %h index %0d last %b, %s %h index %0d last %b",
                     what, want.digest_word, want.word_index, want.last_word,
                     "got word", got.digest_word, got.word_index, got.last_word);
    endfunction

    // offer one request, wait for it to be taken, then predict its digest
    task automatic send_request(input sha256_in_t req, input logic known,
                                input logic [255:0] known_digest);
        int idle_pct;
        int i;
        logic [255:0] digest;
        sha256_out_t word;
        case (idle_phase)
            0: idle_pct = 21;
            1: idle_pct = 76;
            default: idle_pct = 0;
        endcase
        while ($urandom_range(0, 99) < idle_pct)
        begin
            msg_valid <= 1'b0;
            @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg_item <= req;
        forever
        begin
            @(negedge clk);
            if (!msg_stall)
                break;
        end
        @(posedge clk);
        items_sent++;
        if (absorb_request(req, digest))
        begin
            if (known)
                digest = known_digest;
            for (i = 0; i < 8; i++)
            begin
                word.digest_word = digest[255 - 32*i -: 32];
                word.word_index = i[2:0];
                word.last_word = (i == 7);
                digest_words_q.push_back(word);
            end
        end
    endtask

    task automatic send_random_message();
        int len;
        int pick;
        int k;
        bit end_empty;
        sha256_in_t req;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            len = $urandom_range(0, 12);
        else if (pick < 9)
            len = $urandom_range(52, 68);    // around the padding spill and block edge
        else
            len = $urandom_range(110, 135);
        end_empty = (len == 0) || ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                req.data_byte = 8'($urandom);
                req.has_byte = 1'b0;
                req.last = 1'b0;
                send_request(req, 1'b0, '0);
            end
            req.data_byte = 8'($urandom);
            req.has_byte = 1'b1;
            req.last = !end_empty && (k == len - 1);
            send_request(req, 1'b0, '0);
        end
        if (end_empty)
        begin
            req.data_byte = 8'($urandom);
            req.has_byte = 1'b0;
            req.last = 1'b1;
            send_request(req, 1'b0, '0);
        end
    endtask

    // receiver stall pattern, with one long hold-off when the last phase starts
    initial
    begin
        int idle_pct;
        forever
        begin
            @(posedge clk);
            if (idle_phase == 2 && !pressure_done)
            begin
                pressure_done = 1'b1;
                digest_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case (idle_phase)
                0: idle_pct = 76;
                1: idle_pct = 21;
                default: idle_pct = 0;
            endcase
            digest_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    // digest words are checked on the falling edge before the rising edge that takes them
    initial
    begin
        sha256_out_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && digest_valid && !digest_stall)
            begin
                if (digest_words_q.size() == 0)
                    flag_mismatch("no result expected", '0, digest_item);
                else
                begin
                    want = digest_words_q.pop_front();
                    if (digest_item.digest_word !== want.digest_word ||
                        digest_item.word_index !== want.word_index ||
                        digest_item.last_word !== want.last_word)
                        flag_mismatch("digest word", want, digest_item);
                end
            end
        end
    end

    initial
    begin
        sha256_in_t req;
        int r;
        rst_n <= 1'b0;
        directed_script = '{
            '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},          // no byte, no end: ignored
            '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message
            '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},      // byte carries the end
            '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
            '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'hff, 1'b0, 1'b1, 1'b0, 256'h0},          // end after bytes already taken
            '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
            '{8'h5a, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0}
        };
        restart_hash();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (r = 0; r < $size(directed_script); r++)
        begin
            req.data_byte = directed_script[r].data_byte;
            req.has_byte = directed_script[r].has_byte;
            req.last = directed_script[r].last;
            send_request(req, directed_script[r].known, directed_script[r].digest);
        end
        while (items_sent < ITEM_COUNT)
        begin
            if (items_sent >= 2 * ITEM_COUNT / 3)
                idle_phase = 2;
            else if (items_sent >= ITEM_COUNT / 3)
                idle_phase = 1;
            send_random_message();
        end
        msg_valid <= 1'b0;
        while (digest_words_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
